>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the core RTL. They are empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/wam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard matcher package
// Constants, operation codes and the structs passed along the cell row.
// ----------------------------------------------------------------------------
package wam_pkg;

  localparam int unsigned PATTERN_CAPACITY = 64;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OFF_W = 6;
  localparam int unsigned MODE_W = 2;

  localparam logic [BYTE_W-1:0] CHR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHR_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CHR_QMARK = 8'h3F;
  localparam logic [BYTE_W-1:0] CHR_BAR = 8'h7C;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT = 2'd2,
    MODE_END = 2'd3
  } mode_e;

  typedef struct packed {
    logic wr;
    logic start;
    logic [OFF_W-1:0] off;
    logic act_en;
    logic restart;
    logic [BYTE_W-1:0] data;
  } cell_ctl_t;

  typedef struct packed {
    logic fwd;
    logic closed;
    logic star;
    logic bar;
    logic used;
    logic [OFF_W-1:0] off;
  } cell_link_t;

endpackage

>>> rtl/core/wam_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard matcher cell
// One pattern position: stored byte, alternative start and offset, and one
// NFA state bit. Passes its step and star closure to the next cell.
// ----------------------------------------------------------------------------
module wam_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wam_pkg::cell_ctl_t             ctl_i,
  input  logic [CNT_W-1:0]               count_i,
  input  logic [CNT_W-1:0]               count_next_i,
  input  wam_pkg::cell_link_t            link_i,
  output wam_pkg::cell_link_t            link_o,
  output logic                           hit_o,
  output logic [wam_pkg::OFF_W-1:0]      hit_off_o
);
  import wam_pkg::*;

  localparam logic [CNT_W-1:0] Idx = CNT_W'(IDX);

  logic [BYTE_W-1:0] pat_q, pat_d;
  logic              start_q, start_d;
  logic [OFF_W-1:0]  off_q;
  logic              act_q, act_d;
  logic              wr_here, used, tail, is_star, is_bar, is_qm, raw;

  assign wr_here = ctl_i.wr && (count_i == Idx);
  assign pat_d   = wr_here ? ctl_i.data : pat_q;
  assign start_d = wr_here ? ctl_i.start : start_q;
  assign used    = Idx < count_next_i;
  assign tail    = Idx == count_next_i;
  assign is_star = used && (pat_d == CHR_STAR);
  assign is_bar  = used && (pat_d == CHR_BAR);
  assign is_qm   = used && (pat_d == CHR_QMARK);

  assign raw   = ctl_i.restart ? (start_d && used) : ((act_q && is_star) || link_i.fwd);
  assign act_d = raw || (link_i.closed && link_i.star);

  assign link_o.fwd    = act_q && used && !is_star && !is_bar &&
                         (is_qm || (pat_d == ctl_i.data));
  assign link_o.closed = act_d;
  assign link_o.star   = is_star;
  assign link_o.bar    = is_bar;
  assign link_o.used   = used;
  assign link_o.off    = off_q;

  assign hit_o     = act_q && (used ? is_bar : (tail && link_i.used && !link_i.bar));
  assign hit_off_o = used ? off_q : link_i.off;

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      pat_q   <= ctl_i.data;
      start_q <= ctl_i.start;
      off_q   <= ctl_i.off;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctl_i.act_en) begin
      act_q <= act_d;
    end
  end

endmodule

>>> rtl/core/wam_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard matcher first-hit pick
// Isolates the lowest accepting position and selects its alternative offset.
// ----------------------------------------------------------------------------
module wam_pick #(
  parameter int unsigned NUM = 65
) (
  input  logic [NUM-1:0]                        hit_i,
  input  logic [NUM-1:0][wam_pkg::OFF_W-1:0]    off_i,
  output logic                                  matched_o,
  output logic [wam_pkg::OFF_W-1:0]             offset_o
);
  import wam_pkg::*;

  logic [NUM-1:0] first;

  assign first     = hit_i & (~hit_i + NUM'(1));
  assign matched_o = |hit_i;

  always_comb begin
    offset_o = '0;
    for (int k = 0; k < NUM; k++) begin
      offset_o = offset_o | (first[k] ? off_i[k] : '0);
    end
  end

endmodule

>>> rtl/core/wildcard_alternatives_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard alternatives matcher
// Loads a '|'-separated list of glob alternatives into a row of cells and
// runs text through a bit-parallel NFA, reporting the first matching
// alternative at end of text.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    mode_i, byte_value_i
//   out      output     out_valid_o / out_ready_i  matched_o, match_offset_o,
//                                                  pattern_overflow_o
//
// A new item can be accepted in every cycle while in_ready_o is high.
// A result is registered in the output register, or in the skid one if busy.
// The NFA update and star closure ripple combinationally through the cell row.
// in_ready_o drops only while the skid register holds a second result.
// Reset clears the count and the NFA; stored bytes are never cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_alternatives_matcher_core #(
  parameter int unsigned PATTERN_CAPACITY = wam_pkg::PATTERN_CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wam_pkg::MODE_W-1:0]    mode_i,
  input  logic [wam_pkg::BYTE_W-1:0]    byte_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic [wam_pkg::OFF_W-1:0]     match_offset_o,
  output logic                          pattern_overflow_o
);
  import wam_pkg::*;

  localparam int unsigned N = PATTERN_CAPACITY;
  localparam int unsigned CNT_W = $clog2(N + 1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(N);

  mode_e            mode;
  logic             accept, give;
  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count_q, count_d, raw_q, raw_d;
  logic             list_term_q, list_term_d, text_term_q, text_term_d;
  logic             ovf_q, ovf_d, last_star_q, last_star_d, last_bar_q, last_bar_d;
  logic [OFF_W-1:0] cur_off_q, cur_off_d;
  logic             end_act_q, end_act_d;

  cell_link_t                 links [N+1];
  logic [N:0]                 hits;
  logic [N:0][OFF_W-1:0]      offs;
  logic                       pick_matched;
  logic [OFF_W-1:0]           pick_offset;

  logic             out_valid_q, skid_valid_q;
  logic             out_matched_q, out_ovf_q, skid_matched_q, skid_ovf_q;
  logic [OFF_W-1:0] out_off_q, skid_off_q;
  logic             out_fire;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    count_d     = count_q;
    raw_d       = raw_q;
    list_term_d = list_term_q;
    text_term_d = text_term_q;
    ovf_d       = ovf_q;
    last_star_d = last_star_q;
    last_bar_d  = last_bar_q;
    cur_off_d   = cur_off_q;
    give        = 1'b0;
    ctl         = '0;
    ctl.data    = byte_value_i;
    ctl.start   = (count_q == '0) || last_bar_q;
    ctl.off     = ctl.start ? OFF_W'(raw_q) : cur_off_q;
    if (accept) begin
      unique case (mode)
        MODE_CLEAR: begin
          count_d     = '0;
          raw_d       = '0;
          list_term_d = 1'b0;
          ovf_d       = 1'b0;
          text_term_d = 1'b0;
          ctl.restart = 1'b1;
          ctl.act_en  = 1'b1;
        end
        MODE_APPEND: begin
          if (!list_term_q) begin
            ctl.restart = 1'b1;
            ctl.act_en  = 1'b1;
            text_term_d = 1'b0;
            if (byte_value_i == CHR_NUL) begin
              list_term_d = 1'b1;
            end else if (raw_q >= CntMax) begin
              ovf_d = 1'b1;
            end else begin
              raw_d = CNT_W'(raw_q + 1'b1);
              if (!((byte_value_i == CHR_QMARK) && (count_q != '0) && last_star_q)) begin
                ctl.wr      = 1'b1;
                count_d     = CNT_W'(count_q + 1'b1);
                last_star_d = byte_value_i == CHR_STAR;
                last_bar_d  = byte_value_i == CHR_BAR;
                cur_off_d   = ctl.off;
              end
            end
          end
        end
        MODE_TEXT: begin
          if (!text_term_q) begin
            if (byte_value_i == CHR_NUL) begin
              give        = 1'b1;
              text_term_d = 1'b1;
            end else begin
              ctl.act_en = 1'b1;
            end
          end
        end
        MODE_END: begin
          ctl.restart = 1'b1;
          ctl.act_en  = 1'b1;
          text_term_d = 1'b0;
          give        = !text_term_q;
        end
      endcase
    end
  end

  assign links[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    wam_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .count_i      (count_q),
      .count_next_i (count_d),
      .link_i       (links[k]),
      .link_o       (links[k+1]),
      .hit_o        (hits[k]),
      .hit_off_o    (offs[k])
    );
  end

  assign end_act_d = (ctl.restart ? 1'b0 : links[N].fwd) || (links[N].closed && links[N].star);
  assign hits[N]   = end_act_q && links[N].used && !links[N].bar;
  assign offs[N]   = links[N].off;

  wam_pick #(
    .NUM (N + 1)
  ) u_pick (
    .hit_i     (hits),
    .off_i     (offs),
    .matched_o (pick_matched),
    .offset_o  (pick_offset)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      raw_q       <= '0;
      list_term_q <= 1'b0;
      text_term_q <= 1'b0;
      ovf_q       <= 1'b0;
      last_star_q <= 1'b0;
      last_bar_q  <= 1'b0;
      cur_off_q   <= '0;
      end_act_q   <= 1'b0;
    end else begin
      count_q     <= count_d;
      raw_q       <= raw_d;
      list_term_q <= list_term_d;
      text_term_q <= text_term_d;
      ovf_q       <= ovf_d;
      last_star_q <= last_star_d;
      last_bar_q  <= last_bar_d;
      cur_off_q   <= cur_off_d;
      if (ctl.act_en) begin
        end_act_q <= end_act_d;
      end
    end
  end

  assign out_fire = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (give) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_matched_q <= skid_matched_q;
        out_off_q     <= skid_off_q;
        out_ovf_q     <= skid_ovf_q;
      end
    end else if (give) begin
      if (!out_valid_q || out_fire) begin
        out_matched_q <= pick_matched;
        out_off_q     <= pick_offset;
        out_ovf_q     <= ovf_q;
      end else begin
        skid_matched_q <= pick_matched;
        skid_off_q     <= pick_offset;
        skid_ovf_q     <= ovf_q;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = out_matched_q;
  assign match_offset_o     = out_off_q;
  assign pattern_overflow_o = out_ovf_q;

  `ASSERT_IMPLIES(a_skid_needs_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid full while output empty")
  `ASSERT_ALWAYS(a_count_le_raw, clk_i, rst_ni, count_q <= raw_q, "stored count exceeds raw count")
  `ASSERT_NEXT(a_busy_result_to_skid, clk_i, rst_ni, give && out_valid_q && !out_ready_i, skid_valid_q, "result lost while output busy")
  `ASSERT_IMPLIES(a_no_write_after_nul, clk_i, rst_ni, list_term_q, !ctl.wr, "pattern write after list end")

endmodule
